[rtl/core/mfq_pkg.sv]
package mfq_pkg;

    localparam int MFQ_DEPTH = 16;

    localparam int TYPE_W   = 16;
    localparam int ARG_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int QUEUED_W = 5;

    localparam int IN_W     = CMD_W + TYPE_W + 2 * ARG_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W    = STATUS_W + TYPE_W + 2 * ARG_W + QUEUED_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_FLUSH  = 3'd3,
        CMD_START  = 3'd4,
        CMD_STOP   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ABORTED = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic        [TYPE_W-1:0] kind;
        logic signed [ARG_W-1:0]  first;
        logic signed [ARG_W-1:0]  second;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic get_take;
        logic purge_step;
        logic out_load;
    } ctl_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic get_go;
        logic purge_go;
        logic purge_done;
        logic out_free;
    } stat_t;

endpackage

[rtl/core/mfq_ram.sv]
module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/mfq_datapath.sv]
module mfq_datapath
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = MFQ_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    input  ctl_t                   ctl,
    output stat_t                  stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES*8-1:0] m_tdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    // Ring position base + off, with off below twice the depth in practice.
    function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    cmd_t                 cmd_reg, cmd_next;
    logic [TYPE_W-1:0]    kind_reg, kind_next;
    logic [ARG_W-1:0]     first_reg, first_next;
    logic [ARG_W-1:0]     second_reg, second_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 aborted_reg, aborted_next;
    logic [CNT_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     wr_reg, wr_next;
    logic                 pend_reg, pend_next;
    status_t              res_status_reg, res_status_next;
    entry_t               got_reg, got_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_BYTES*8-1:0] m_data_reg, m_data_next;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [PTR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;
    entry_t               new_entry;
    logic [CNT_W+QUEUED_W-1:0] count_ext;
    logic [QUEUED_W-1:0]  queued;
    logic                 full;
    logic                 empty;

    assign rd_entry  = entry_t'(ram_rdata);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign count_ext = (CNT_W + QUEUED_W)'(count_reg);
    assign queued    = count_ext[QUEUED_W-1:0];

    assign new_entry.kind   = kind_reg;
    assign new_entry.first  = first_reg;
    assign new_entry.second = second_reg;

    assign stat.get_go     = (cmd_reg == CMD_GET) && !aborted_reg && !empty;
    assign stat.purge_go   = (cmd_reg == CMD_REMOVE) && !aborted_reg;
    assign stat.purge_done = (rd_reg == count_reg) && !pend_reg;
    assign stat.out_free   = !m_valid_reg || m_tready;

    // During a purge the read side runs at head + rd, otherwise it sits at the head.
    assign ram_raddr = ctl.purge_step ? wrap_add(head_reg, rd_reg) : head_reg;

    always_comb begin
        cmd_next        = cmd_reg;
        kind_next       = kind_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        aborted_next    = aborted_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        got_next        = got_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = wrap_add(head_reg, count_reg);
        ram_wdata       = new_entry;

        if (ctl.load_item) begin
            cmd_next    = cmd_t'(s_tdata[CMD_W-1:0]);
            kind_next   = s_tdata[CMD_W +: TYPE_W];
            first_next  = s_tdata[CMD_W+TYPE_W +: ARG_W];
            second_next = s_tdata[CMD_W+TYPE_W+ARG_W +: ARG_W];
        end

        if (ctl.exec) begin
            res_status_next = ST_OK;
            got_next        = '0;
            case (cmd_reg)
                CMD_PUT: begin
                    if (aborted_reg) begin
                        res_status_next = ST_ABORTED;
                    end else if (full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_GET: begin
                    if (aborted_reg) begin
                        res_status_next = ST_ABORTED;
                    end else if (empty) begin
                        res_status_next = ST_EMPTY;
                    end
                end
                CMD_REMOVE: begin
                    rd_next   = '0;
                    wr_next   = '0;
                    pend_next = 1'b0;
                end
                CMD_FLUSH: begin
                    count_next = '0;
                end
                CMD_START: begin
                    aborted_next = 1'b0;
                end
                CMD_STOP: begin
                    aborted_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (ctl.get_take) begin
            got_next   = rd_entry;
            head_next  = wrap_add(head_reg, CNT_W'(1));
            count_next = count_reg - CNT_W'(1);
        end

        // Compaction: reads run at least one entry ahead of the writes, so the write
        // slot never overtakes an entry that still has to be read.
        if (ctl.purge_step) begin
            if (rd_reg != count_reg) begin
                rd_next   = rd_reg + CNT_W'(1);
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
            if (pend_reg && (rd_entry.kind != kind_reg)) begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(head_reg, wr_reg);
                ram_wdata = rd_entry;
                wr_next   = wr_reg + CNT_W'(1);
            end
            if (stat.purge_done) begin
                count_next = wr_reg;
            end
        end

        if (ctl.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = (OUT_BYTES*8)'({queued, got_reg.second, got_reg.first,
                                          got_reg.kind, res_status_reg});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            aborted_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            aborted_reg <= aborted_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        kind_reg       <= kind_next;
        first_reg      <= first_next;
        second_reg     <= second_next;
        rd_reg         <= rd_next;
        wr_reg         <= wr_next;
        res_status_reg <= res_status_next;
        got_reg        <= got_next;
        m_data_reg     <= m_data_next;
    end

    mfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_purge_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.purge_step |-> wr_reg <= rd_reg)
        else $error("purge write index passed read index");

    a_get_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.get_take |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("get did not remove exactly one entry");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.exec && (cmd_reg == CMD_FLUSH) |=> count_reg == '0)
        else $error("flush left entries in the queue");

endmodule

[rtl/core/mfq_ctrl.sv]
module mfq_ctrl
    import mfq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output ctl_t  ctl,
    input  stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GET,
        S_PURGE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.load_item  = s_tvalid && ready_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                ctl.exec = 1'b1;
                if (stat.get_go) begin
                    state_next = S_GET;
                end else if (stat.purge_go) begin
                    state_next = S_PURGE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_GET: begin
                ctl.get_take = 1'b1;
                state_next   = S_OUT;
            end
            S_PURGE: begin
                ctl.purge_step = 1'b1;
                if (stat.purge_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                ctl.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

[rtl/core/message_fifo_with_type_purge.sv]
// Each accepted item steps through EXEC, then GET for a get that finds an entry or
// PURGE for a remove while not stopped, then OUT, where its reply is loaded into the
// output register once that register is free (one entry read and compacted per cycle
// through the entry RAM during PURGE). No new item is taken until that reply is loaded.
// Reset (aresetn low, synchronous): queue empty, not aborted, no result pending.
module message_fifo_with_type_purge
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = MFQ_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // command[2:0], msg_type[18:3], first_arg[50:19], second_arg[82:51], zero pad
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[1:0], got_type[17:2], got_first[49:18], got_second[81:50],
    // queued[86:82], zero pad
    output logic [OUT_BYTES*8-1:0] m_tdata
);

    ctl_t  ctl;
    stat_t stat;

    mfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .stat     (stat)
    );

    mfq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .ctl      (ctl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[tb/queue_reply_checker.sv]
module queue_reply_checker
    import mfq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // command, msg_type, first_arg, second_arg, zero pad
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // status, got_type, got_first, got_second, queued, zero pad
    input  logic [OUT_BYTES*8-1:0] m_tdata,
    output int                     error_count,
    output int                     replies_due,
    output int                     replies_checked,
    output int                     msgs_delivered,
    output int                     full_rejects,
    output int                     abort_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_KIND_LSB   = CMD_W;
    localparam int IN_FIRST_LSB  = CMD_W + TYPE_W;
    localparam int IN_SECOND_LSB = CMD_W + TYPE_W + ARG_W;

    localparam int OUT_TYPE_LSB   = STATUS_W;
    localparam int OUT_FIRST_LSB  = STATUS_W + TYPE_W;
    localparam int OUT_SECOND_LSB = STATUS_W + TYPE_W + ARG_W;
    localparam int OUT_QUEUED_LSB = STATUS_W + TYPE_W + 2 * ARG_W;

    typedef struct {
        status_t                  status;
        logic        [TYPE_W-1:0] got_type;
        logic signed [ARG_W-1:0]  got_first;
        logic signed [ARG_W-1:0]  got_second;
        logic      [QUEUED_W-1:0] queued;
        logic                     delivered;
    } reply_t;

    entry_t held_msgs[$];
    logic   halted;
    reply_t due_replies[$];

    function automatic reply_t predict_reply(input logic [CMD_W-1:0] cmd, input entry_t msg);
        reply_t r;
        entry_t kept[$];
        r = '{status: ST_OK, got_type: '0, got_first: '0, got_second: '0, queued: '0,
              delivered: 1'b0};
        case (cmd)
            CMD_PUT: begin
                // The abort flag wins over a full queue.
                if (halted) begin
                    r.status = ST_ABORTED;
                end else if (held_msgs.size() >= MFQ_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_msgs.push_back(msg);
                end
            end
            CMD_GET: begin
                if (halted) begin
                    r.status = ST_ABORTED;
                end else if (held_msgs.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.got_type   = held_msgs[0].kind;
                    r.got_first  = held_msgs[0].first;
                    r.got_second = held_msgs[0].second;
                    r.delivered  = 1'b1;
                    void'(held_msgs.pop_front());
                end
            end
            CMD_REMOVE: begin
                if (!halted) begin
                    foreach (held_msgs[i]) begin
                        if (held_msgs[i].kind != msg.kind) begin
                            kept.push_back(held_msgs[i]);
                        end
                    end
                    held_msgs = kept;
                end
            end
            CMD_FLUSH: begin
                held_msgs.delete();
            end
            CMD_START: begin
                halted = 1'b0;
            end
            CMD_STOP: begin
                halted = 1'b1;
            end
            default: begin
            end
        endcase
        r.queued = QUEUED_W'(held_msgs.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        entry_t msg;
        reply_t seen;
        reply_t want;
        if (!aresetn) begin
            held_msgs.delete();
            due_replies.delete();
            halted          = 1'b0;
            error_count     = 0;
            replies_due     = 0;
            replies_checked = 0;
            msgs_delivered  = 0;
            full_rejects    = 0;
            abort_rejects   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                msg.kind   = s_tdata[IN_KIND_LSB +: TYPE_W];
                msg.first  = s_tdata[IN_FIRST_LSB +: ARG_W];
                msg.second = s_tdata[IN_SECOND_LSB +: ARG_W];
                due_replies.push_back(predict_reply(s_tdata[CMD_W-1:0], msg));
            end
            if (m_tvalid && m_tready) begin
                seen.status     = status_t'(m_tdata[STATUS_W-1:0]);
                seen.got_type   = m_tdata[OUT_TYPE_LSB +: TYPE_W];
                seen.got_first  = m_tdata[OUT_FIRST_LSB +: ARG_W];
                seen.got_second = m_tdata[OUT_SECOND_LSB +: ARG_W];
                seen.queued     = m_tdata[OUT_QUEUED_LSB +: QUEUED_W];
                seen.delivered  = 1'b0;
                replies_checked++;
                if (due_replies.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("[%0t] reply item with nothing outstanding: status %0d queued %0d",
                                 $time, seen.status, seen.queued);
                    end
                end else begin
                    want = due_replies.pop_front();
                    if (want.delivered) begin
                        msgs_delivered++;
                    end
                    if (want.status == ST_FULL) begin
                        full_rejects++;
                    end
                    if (want.status == ST_ABORTED) begin
                        abort_rejects++;
                    end
                    if (seen.status !== want.status || seen.got_type !== want.got_type ||
                        seen.got_first !== want.got_first ||
                        seen.got_second !== want.got_second || seen.queued !== want.queued) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("[%0t] reply mismatch (expected/actual): status %0d/%0d",
                                     $time, want.status, seen.status);
                            $display("    type %h/%h first %0d/%0d second %0d/%0d queued %0d/%0d",
                                     want.got_type, seen.got_type, want.got_first,
                                     seen.got_first, want.got_second, seen.got_second,
                                     want.queued, seen.queued);
                        end
                    end
                end
            end
            replies_due = due_replies.size();
        end
    end

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mfq_pkg::*;

    // Codes outside the command set; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 850;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_BYTES*8-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0] m_tdata;

    logic calm        = 1'b0;
    logic halted_hint = 1'b0;
    logic stuck       = 1'b0;
    int   items_sent  = 0;

    int error_count;
    int replies_due;
    int replies_checked;
    int msgs_delivered;
    int full_rejects;
    int abort_rejects;

    message_fifo_with_type_purge uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    queue_reply_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .replies_due     (replies_due),
        .replies_checked (replies_checked),
        .msgs_delivered  (msgs_delivered),
        .full_rejects    (full_rejects),
        .abort_rejects   (abort_rejects)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TYPE_W-1:0] kind,
                             input logic [ARG_W-1:0] first, input logic [ARG_W-1:0] second);
        while (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= (IN_BYTES*8)'({second, first, kind, cmd});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (cmd == CMD_STOP) begin
            halted_hint = 1'b1;
        end else if (cmd == CMD_START) begin
            halted_hint = 1'b0;
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (replies_due != 0) @(negedge aclk);
    endtask

    function automatic logic [ARG_W-1:0] pick_arg();
        logic [ARG_W-1:0] v;
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = '0;
                default: v = '1;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // Mostly puts and gets over a small set of types so that removes find matches.
    task automatic send_random(input int put_pct);
        int               roll;
        logic [CMD_W-1:0] cmd;
        logic [TYPE_W-1:0] kind;
        roll = $urandom_range(99);
        if (halted_hint && roll < 40) begin
            cmd = CMD_START;
        end else begin
            roll = $urandom_range(99);
            if (roll < put_pct) begin
                cmd = CMD_PUT;
            end else if (roll < 88) begin
                cmd = CMD_GET;
            end else if (roll < 94) begin
                cmd = CMD_REMOVE;
            end else if (roll < 95) begin
                cmd = CMD_FLUSH;
            end else if (roll < 97) begin
                cmd = CMD_STOP;
            end else if (roll < 98) begin
                cmd = CMD_START;
            end else begin
                cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            end
        end
        if ($urandom_range(99) < 80) begin
            kind = TYPE_W'($urandom_range(3));
        end else begin
            kind = TYPE_W'($urandom);
        end
        send_item(cmd, kind, pick_arg(), pick_arg());
    endtask

    initial begin
        int put_pct;
        int waited;
        put_pct = 45;
        waited  = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(CMD_GET, 16'h0000, '0, '0);
        send_item(CMD_PUT, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(CMD_PUT, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int n = 2; n < MFQ_DEPTH; n++) begin
            send_item(CMD_PUT, (n % 3 == 0) ? 16'hFFFF : TYPE_W'(n % 3), $urandom, $urandom);
        end
        send_item(CMD_PUT, 16'h0005, '0, '1);
        send_item(CMD_REMOVE, 16'hFFFF, '0, '0);
        send_item(CMD_GET, 16'h0000, '0, '0);
        send_item(CMD_STOP, 16'h0000, '0, '0);
        // While stopped: put and get are refused, remove is ignored, flush still empties.
        send_item(CMD_PUT, 16'h0003, '1, '1);
        send_item(CMD_GET, 16'h0000, '0, '0);
        send_item(CMD_REMOVE, 16'h0001, '0, '0);
        send_item(CMD_FLUSH, 16'h0000, '0, '0);
        send_item(CMD_START, 16'h0000, '0, '0);
        send_item(CMD_SPARE_LO, 16'hFFFF, '1, '1);
        send_item(CMD_SPARE_HI, 16'hFFFF, '1, '1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(2))
                    0: put_pct = 65;
                    1: put_pct = 25;
                    default: put_pct = 45;
                endcase
            end
            calm = (i >= 400 && i < 550);
            if (i == 200 || i == 650) begin
                drain_replies();
            end
            send_random(put_pct);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        @(negedge aclk);

        while (replies_due != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        stuck = (replies_due != 0);
        repeat (40) @(negedge aclk);

        $display("Sent %0d command items; %0d reply items checked.", items_sent, replies_checked);
        $display("Replies covered %0d delivered messages, %0d full and %0d aborted refusals.",
                 msgs_delivered, full_rejects, abort_rejects);
        if (error_count == 0 && !stuck && replies_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
